>>> design/klq_pkg.sv
// klq_pkg: shared constants, types and helpers for the keep-last queue
// no dependencies; imported by every other design file except klq_ram
package klq_pkg;

    localparam int MAX_DEPTH  = 16;
    localparam int IDX_W      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CNT_W      = $clog2(MAX_DEPTH + 1);
    localparam int DEPTH_W    = 5;
    localparam int TIME_W     = 64;
    localparam int HANDLE_W   = 32;
    localparam int PSEQ_W     = 16;
    localparam int RSEQ_W     = 32;
    localparam int LEVEL_W    = 5;
    localparam int LEVEL_MAX  = (1 << LEVEL_W) - 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd16;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_TAKE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUEUE_DEPTH = 2'd0,
        CFG_LIFESPAN    = 2'd1
    } cfg_idx_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   source_time;
        logic [TIME_W-1:0]   received_time;
        logic [PSEQ_W-1:0]   publication_seq;
        logic [RSEQ_W-1:0]   reception_seq;
    } entry_t;

    typedef struct packed {
        logic                taken;
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   source_time;
        logic [TIME_W-1:0]   received_time;
        logic [PSEQ_W-1:0]   publication_seq;
        logic [RSEQ_W-1:0]   reception_seq;
        logic                dropped;
        logic [LEVEL_W-1:0]  expired;
        logic [LEVEL_W-1:0]  level;
    } res_t;

    typedef struct packed {
        logic accept;
        logic push;
        logic expire;
        logic take_done;
    } klq_cmd_t;

    typedef struct packed {
        logic req_valid;
        logic req_func;
        logic empty;
        logic expire_hit;
        logic out_free;
    } klq_stat_t;

    function automatic logic [LEVEL_W-1:0] sat_level(input logic [CNT_W-1:0] v);
        if (int'(v) > LEVEL_MAX)
            return LEVEL_W'(LEVEL_MAX);
        return LEVEL_W'(v);
    endfunction

    // slot sums stay below twice the ring size
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [CNT_W:0] s);
        logic [CNT_W:0] r;
        r = (s >= (CNT_W+1)'(MAX_DEPTH)) ? s - (CNT_W+1)'(MAX_DEPTH) : s;
        return IDX_W'(r);
    endfunction

endpackage

>>> design/klq_req_if.sv
// klq_req_if: request channel carrying one queue operation per beat
// depends on klq_pkg
interface klq_req_if import klq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                func;
    logic [TIME_W-1:0]   now_time;
    logic [TIME_W-1:0]   source_time;
    logic [PSEQ_W-1:0]   publication_seq;
    logic [HANDLE_W-1:0] message_handle;

    modport source (
        output valid, func, now_time, source_time, publication_seq, message_handle,
        input  ready
    );
    modport sink (
        input  valid, func, now_time, source_time, publication_seq, message_handle,
        output ready
    );
endinterface

>>> design/klq_rsp_if.sv
// klq_rsp_if: result channel, one result beat per operation
// depends on klq_pkg
interface klq_rsp_if import klq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                taken;
    logic [HANDLE_W-1:0] out_message_handle;
    logic [TIME_W-1:0]   out_source_time;
    logic [TIME_W-1:0]   out_received_time;
    logic [PSEQ_W-1:0]   out_publication_seq;
    logic [RSEQ_W-1:0]   out_reception_seq;
    logic                dropped_oldest;
    logic [LEVEL_W-1:0]  expired_count;
    logic [LEVEL_W-1:0]  queue_level;

    modport source (
        output valid, taken, out_message_handle, out_source_time, out_received_time,
               out_publication_seq, out_reception_seq, dropped_oldest, expired_count,
               queue_level,
        input  ready
    );
    modport sink (
        input  valid, taken, out_message_handle, out_source_time, out_received_time,
               out_publication_seq, out_reception_seq, dropped_oldest, expired_count,
               queue_level,
        output ready
    );
endinterface

>>> design/klq_ram.sv
// klq_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module klq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/klq_ctrl.sv
// klq_ctrl: sequencer for push, expiry scan and take
// depends on klq_pkg; drives the datapath through klq_cmd_t
module klq_ctrl import klq_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  klq_stat_t stat,
    output klq_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH,
        ST_FETCH,
        ST_EXAM
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = 1'b1;
                if (stat.req_valid)
                begin
                    state_next = (stat.req_func == FUNC_TAKE) ? ST_FETCH : ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            // head entry read is in flight
            ST_FETCH:
            begin
                state_next = ST_EXAM;
            end
            ST_EXAM:
            begin
                if (!stat.empty && stat.expire_hit)
                begin
                    cmd.expire = 1'b1;
                    state_next = ST_FETCH;
                end
                else if (stat.out_free)
                begin
                    cmd.take_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/klq_datapath.sv
// klq_datapath: ring store, pointers, config registers, expiry compare, result register
// depends on klq_pkg, klq_req_if, klq_rsp_if, klq_ram
module klq_datapath import klq_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  klq_cmd_t              cmd,
    output klq_stat_t             stat,
    klq_req_if.sink               req,
    klq_rsp_if.source             rsp
);

    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [TIME_W-1:0]  life_reg, life_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [RSEQ_W-1:0]  rseq_reg, rseq_next;
    logic [CNT_W-1:0]   exp_reg, exp_next;
    logic               out_valid_reg, out_valid_next;
    res_t               out_reg, out_next;

    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   src_reg;
    logic [PSEQ_W-1:0]   pseq_reg;
    logic [HANDLE_W-1:0] handle_reg;

    logic [CNT_W-1:0]           eff_depth;
    logic                       full;
    logic [IDX_W-1:0]           head_inc;
    logic [IDX_W-1:0]           tail_idx;
    entry_t                     wr_entry;
    logic [$bits(entry_t)-1:0]  rd_bits;
    entry_t                     rd_entry;
    logic [TIME_W-1:0]          age;

    always_comb
    begin
        if (depth_reg == '0)
            eff_depth = CNT_W'(1);
        else if (int'(depth_reg) > MAX_DEPTH)
            eff_depth = CNT_W'(MAX_DEPTH);
        else
            eff_depth = CNT_W'(depth_reg);
    end

    assign full     = (count_reg >= eff_depth);
    assign head_inc = wrap_idx((CNT_W+1)'(head_reg) + (CNT_W+1)'(1));
    // a drop moves head up and keeps count, so the new entry goes to the old head + count
    assign tail_idx = wrap_idx((CNT_W+1)'(head_reg) + (CNT_W+1)'(count_reg));

    always_comb
    begin
        wr_entry.handle          = handle_reg;
        wr_entry.source_time     = src_reg;
        wr_entry.received_time   = now_reg;
        wr_entry.publication_seq = pseq_reg;
        wr_entry.reception_seq   = rseq_reg;
    end

    klq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (tail_idx),
        .wr_data (wr_entry),
        .rd_addr (head_reg),
        .rd_data (rd_bits)
    );

    assign rd_entry = entry_t'(rd_bits);
    assign age      = now_reg - rd_entry.source_time;

    assign stat.req_valid  = req.valid;
    assign stat.req_func   = req.func;
    assign stat.empty      = (count_reg == '0);
    assign stat.expire_hit = (life_reg != '0) && (age >= life_reg);
    assign stat.out_free   = !out_valid_reg || rsp.ready;

    always_comb
    begin
        depth_next     = depth_reg;
        life_next      = life_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        rseq_next      = rseq_reg;
        exp_next       = exp_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_QUEUE_DEPTH:
                begin
                    depth_next = cfg_data[DEPTH_W-1:0];
                    head_next  = '0;
                    count_next = '0;
                end
                CFG_LIFESPAN:
                begin
                    life_next = cfg_data;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.accept && req.valid)
        begin
            exp_next = '0;
        end

        if (cmd.push)
        begin
            rseq_next = rseq_reg + RSEQ_W'(1);
            out_next  = '0;
            if (full)
            begin
                head_next        = head_inc;
                out_next.dropped = 1'b1;
                out_next.level   = sat_level(count_reg);
            end
            else
            begin
                count_next     = count_reg + CNT_W'(1);
                out_next.level = sat_level(count_reg + CNT_W'(1));
            end
            out_valid_next = 1'b1;
        end

        if (cmd.expire)
        begin
            head_next  = head_inc;
            count_next = count_reg - CNT_W'(1);
            exp_next   = exp_reg + CNT_W'(1);
        end

        if (cmd.take_done)
        begin
            out_next         = '0;
            out_next.expired = sat_level(exp_reg);
            out_next.level   = sat_level(count_reg);
            if (count_reg != '0)
            begin
                out_next.taken           = 1'b1;
                out_next.handle          = rd_entry.handle;
                out_next.source_time     = rd_entry.source_time;
                out_next.received_time   = rd_entry.received_time;
                out_next.publication_seq = rd_entry.publication_seq;
                out_next.reception_seq   = rd_entry.reception_seq;
                out_next.level           = sat_level(count_reg - CNT_W'(1));
                head_next                = head_inc;
                count_next               = count_reg - CNT_W'(1);
            end
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= DEPTH_RESET;
            life_reg      <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            rseq_reg      <= '0;
            exp_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg     <= depth_next;
            life_reg      <= life_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rseq_reg      <= rseq_next;
            exp_reg       <= exp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (cmd.accept && req.valid)
        begin
            now_reg    <= req.now_time;
            src_reg    <= req.source_time;
            pseq_reg   <= req.publication_seq;
            handle_reg <= req.message_handle;
        end
    end

    assign req.ready = cmd.accept;

    assign rsp.valid               = out_valid_reg;
    assign rsp.taken               = out_reg.taken;
    assign rsp.out_message_handle  = out_reg.handle;
    assign rsp.out_source_time     = out_reg.source_time;
    assign rsp.out_received_time   = out_reg.received_time;
    assign rsp.out_publication_seq = out_reg.publication_seq;
    assign rsp.out_reception_seq   = out_reg.reception_seq;
    assign rsp.dropped_oldest      = out_reg.dropped;
    assign rsp.expired_count       = out_reg.expired;
    assign rsp.queue_level         = out_reg.level;

endmodule

>>> design/keep_last_queue_with_lifespan.sv
// keep_last_queue_with_lifespan: keep-last ring queue with age-based expiry on take.
// a push result is registered in PUSH; a take reads the head in FETCH, compares in EXAM,
// repeats both per expired head entry, then registers its result; PUSH and EXAM wait
// for a free result register. one operation at a time; the next beat is taken in IDLE;
// a result register lets it be accepted while the last result waits.
// reset: queue empty, depth 16, lifespan 0, reception seq 0; the store is not cleared.
module keep_last_queue_with_lifespan import klq_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    klq_req_if.sink               req,
    klq_rsp_if.source             rsp
);

    klq_cmd_t  cmd;
    klq_stat_t stat;

    klq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    klq_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .req       (req),
        .rsp       (rsp)
    );

    // one operation at a time: acceptance is followed by a busy cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted while an operation is in flight");

    // every expiry drop is followed by a fresh head read
    a_expire_refetch: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.expire |=> !cmd.expire && !cmd.take_done)
        else $error("head examined without a new store read");

    a_take_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.taken |-> !rsp.dropped_oldest)
        else $error("take result flags a dropped entry");

    a_empty_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.taken |-> rsp.out_message_handle == '0 &&
            rsp.out_reception_seq == '0 && rsp.out_source_time == '0)
        else $error("result without a message carries message fields");

endmodule

>>> test/keep_last_queue_with_lifespan_tb.sv
// keep_last_queue_with_lifespan_tb: self-checking bench for the keep-last queue with expiry
// drives push/take beats on klq_req_if, scores klq_rsp_if beats against a local queue model
// depends on klq_pkg, klq_req_if, klq_rsp_if and keep_last_queue_with_lifespan
module keep_last_queue_with_lifespan_tb;
    import klq_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 50;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    klq_req_if req_ch ();
    klq_rsp_if rsp_ch ();

    keep_last_queue_with_lifespan i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // queue model state
    logic [HANDLE_W-1:0] ring_handle   [MAX_DEPTH];
    logic [TIME_W-1:0]   ring_src_time [MAX_DEPTH];
    logic [TIME_W-1:0]   ring_rcv_time [MAX_DEPTH];
    logic [PSEQ_W-1:0]   ring_pub_seq  [MAX_DEPTH];
    logic [RSEQ_W-1:0]   ring_rcv_seq  [MAX_DEPTH];
    int unsigned         ring_head;
    int unsigned         ring_held;
    logic [RSEQ_W-1:0]   next_rcv_seq;
    logic [DEPTH_W-1:0]  depth_setting;
    logic [TIME_W-1:0]   lifespan_setting;

    res_t              expected_results [$];
    int                error_count;
    int                cycle_count;
    int                rsp_hold_cycles;
    bit                sender_burst;
    bit                rsp_burst;
    logic [TIME_W-1:0] sim_now;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("keep_last_queue_with_lifespan_tb: errors");
            $finish;
        end
    end

    function automatic res_t predict_queue_op(logic func, logic [TIME_W-1:0] now,
                                              logic [TIME_W-1:0] src,
                                              logic [PSEQ_W-1:0] pseq,
                                              logic [HANDLE_W-1:0] handle);
        res_t        r;
        int unsigned limit;
        int unsigned tail;
        int unsigned expired;
        r = '0;
        expired = 0;
        limit = (depth_setting == 0) ? 1 :
                ((depth_setting > MAX_DEPTH) ? MAX_DEPTH : int'(depth_setting));
        if (func == FUNC_PUSH)
        begin
            if (ring_held >= limit)
            begin
                ring_head = (ring_head + 1) % MAX_DEPTH;
                ring_held--;
                r.dropped = 1'b1;
            end
            tail = (ring_head + ring_held) % MAX_DEPTH;
            ring_handle[tail]   = handle;
            ring_src_time[tail] = src;
            ring_rcv_time[tail] = now;
            ring_pub_seq[tail]  = pseq;
            ring_rcv_seq[tail]  = next_rcv_seq;
            next_rcv_seq++;
            ring_held++;
        end
        else
        begin
            // age is taken modulo 2^64
            while (ring_held > 0 && lifespan_setting != 0 &&
                   (now - ring_src_time[ring_head]) >= lifespan_setting)
            begin
                ring_head = (ring_head + 1) % MAX_DEPTH;
                ring_held--;
                expired++;
            end
            if (ring_held > 0)
            begin
                r.taken           = 1'b1;
                r.handle          = ring_handle[ring_head];
                r.source_time     = ring_src_time[ring_head];
                r.received_time   = ring_rcv_time[ring_head];
                r.publication_seq = ring_pub_seq[ring_head];
                r.reception_seq   = ring_rcv_seq[ring_head];
                ring_head = (ring_head + 1) % MAX_DEPTH;
                ring_held--;
            end
            r.expired = LEVEL_W'(expired);
        end
        r.level = LEVEL_W'(ring_held);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (error_count < MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic check_result();
        res_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("result beat with nothing pending");
            return;
        end
        want = expected_results.pop_front();
        check_field("taken", 64'(rsp_ch.taken), 64'(want.taken));
        check_field("out_message_handle", 64'(rsp_ch.out_message_handle),
                    64'(want.handle));
        check_field("out_source_time", rsp_ch.out_source_time, want.source_time);
        check_field("out_received_time", rsp_ch.out_received_time, want.received_time);
        check_field("out_publication_seq", 64'(rsp_ch.out_publication_seq),
                    64'(want.publication_seq));
        check_field("out_reception_seq", 64'(rsp_ch.out_reception_seq),
                    64'(want.reception_seq));
        check_field("dropped_oldest", 64'(rsp_ch.dropped_oldest), 64'(want.dropped));
        check_field("expired_count", 64'(rsp_ch.expired_count), 64'(want.expired));
        check_field("queue_level", 64'(rsp_ch.queue_level), 64'(want.level));
    endtask

    // result side: random stall per beat, long hold-off on request
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (rsp_hold_cycles > 0)
                stall = rsp_hold_cycles;
            else
                stall = rsp_burst ? 0 : $urandom_range(0, 14);
            rsp_hold_cycles = 0;
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
            check_result();
            @(negedge clk);
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_op(logic func, logic [TIME_W-1:0] now, logic [TIME_W-1:0] src,
                           logic [PSEQ_W-1:0] pseq, logic [HANDLE_W-1:0] handle);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.func            <= func;
        req_ch.now_time        <= now;
        req_ch.source_time     <= src;
        req_ch.publication_seq <= pseq;
        req_ch.message_handle  <= handle;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        expected_results.push_back(predict_queue_op(func, now, src, pseq, handle));
        @(negedge clk);
    endtask

    task automatic take_at(logic [TIME_W-1:0] now);
        send_op(FUNC_TAKE, now, {$urandom, $urandom}, 16'($urandom), $urandom);
    endtask

    task automatic wait_results_done();
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        wait_results_done();
        // let the queue settle before the config write
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        case (idx)
            CFG_QUEUE_DEPTH:
            begin
                depth_setting = value[DEPTH_W-1:0];
                ring_head = 0;
                ring_held = 0;
            end
            CFG_LIFESPAN: lifespan_setting = value;
            default: ;
        endcase
    endtask

    task automatic test_field_extremes();
        take_at(64'd0);
        send_op(FUNC_PUSH, 64'd0, 64'd0, 16'h0000, 32'h0000_0000);
        send_op(FUNC_PUSH, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF,
                32'hFFFF_FFFF);
        send_op(FUNC_PUSH, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 16'h5A5A,
                32'hA5A5_A5A5);
        repeat (4) take_at(64'd7);
    endtask

    task automatic test_depth_limits();
        write_reg(CFG_QUEUE_DEPTH, 64'd2);
        repeat (3) send_op(FUNC_PUSH, 64'd100, 64'd90, 16'($urandom), $urandom);
        repeat (2) take_at(64'd101);
        // zero depth behaves as one entry
        write_reg(CFG_QUEUE_DEPTH, 64'd0);
        repeat (2) send_op(FUNC_PUSH, 64'd200, 64'd190, 16'($urandom), $urandom);
        take_at(64'd201);
        write_reg(CFG_QUEUE_DEPTH, 64'(DEPTH_RESET));
    endtask

    task automatic test_lifespan_expiry();
        write_reg(CFG_LIFESPAN, 64'd100);
        // age equal to the lifespan expires, one below does not
        send_op(FUNC_PUSH, 64'd1000, 64'd900, 16'h0001, 32'h1111_0001);
        send_op(FUNC_PUSH, 64'd1000, 64'd901, 16'h0002, 32'h1111_0002);
        take_at(64'd1000);
        // age wraps through zero
        send_op(FUNC_PUSH, 64'd10, 64'hFFFF_FFFF_FFFF_FFCE, 16'h0003, 32'h1111_0003);
        take_at(64'd50);
        write_reg(CFG_LIFESPAN, 64'hFFFF_FFFF_FFFF_FFFF);
        send_op(FUNC_PUSH, 64'd5, 64'd1, 16'h0004, 32'h1111_0004);
        take_at(64'd0);
        send_op(FUNC_PUSH, 64'd5, 64'd0, 16'h0005, 32'h1111_0005);
        take_at(64'hFFFF_FFFF_FFFF_FFFE);
    endtask

    task automatic run_random_ops(int count, int unsigned age_span);
        logic              func;
        logic [TIME_W-1:0] src;
        for (int i = 0; i < count; i++)
        begin
            if (i % 16 == 0)
            begin
                sender_burst = ($urandom_range(0, 3) == 0);
                rsp_burst    = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 39) == 0)
                wait_results_done();
            sim_now += 64'($urandom_range(0, age_span / 4 + 1));
            // fill first, then drain
            func = ($urandom_range(0, 99) < ((i < count / 2) ? 70 : 35)) ? FUNC_PUSH
                                                                         : FUNC_TAKE;
            if ($urandom_range(0, 7) == 0)
                src = {$urandom, $urandom};
            else
                src = sim_now - 64'($urandom_range(0, 2 * age_span));
            send_op(func, sim_now, src, 16'($urandom), $urandom);
        end
        sender_burst = 1'b0;
        rsp_burst    = 1'b0;
    endtask

    task automatic test_random_settings();
        logic [DEPTH_W-1:0] depth_list [8];
        logic [TIME_W-1:0]  life_list  [8];
        int unsigned        age_span;
        depth_list = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd5, 5'd17, 5'd8, 5'd3};
        life_list  = '{64'd0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd300, 64'd1000,
                       64'd0, 64'd0, 64'd40};
        life_list[5]  = 64'($urandom_range(1, 5000));
        depth_list[6] = DEPTH_W'($urandom_range(1, MAX_DEPTH));
        for (int p = 0; p < 8; p++)
        begin
            write_reg(CFG_QUEUE_DEPTH, 64'(depth_list[p]));
            write_reg(CFG_LIFESPAN, life_list[p]);
            // one phase runs the clock through the 64-bit wrap
            sim_now  = (p == 4) ? 64'hFFFF_FFFF_FFFF_FC00 : {$urandom, $urandom};
            age_span = (life_list[p] == 0 || life_list[p] > 5000) ? 1000
                                                                  : int'(life_list[p]);
            run_random_ops(64, age_span);
        end
    endtask

    task automatic test_output_stall();
        write_reg(CFG_QUEUE_DEPTH, 64'd4);
        write_reg(CFG_LIFESPAN, 64'd0);
        rsp_hold_cycles = 160;
        sender_burst = 1'b1;
        for (int i = 0; i < 24; i++)
            send_op((i % 3 == 2) ? FUNC_TAKE : FUNC_PUSH, 64'(i), {$urandom, $urandom},
                    16'($urandom), $urandom);
        sender_burst = 1'b0;
        wait_results_done();
        repeat (6) send_op(FUNC_PUSH, {$urandom, $urandom}, {$urandom, $urandom},
                           16'($urandom), $urandom);
        repeat (3) take_at({$urandom, $urandom});
    endtask

    initial
    begin
        clk                    = 1'b0;
        rst_n                  = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_index              = CFG_QUEUE_DEPTH;
        cfg_data               = '0;
        req_ch.valid           = 1'b0;
        req_ch.func            = FUNC_PUSH;
        req_ch.now_time        = '0;
        req_ch.source_time     = '0;
        req_ch.publication_seq = '0;
        req_ch.message_handle  = '0;
        rsp_ch.ready           = 1'b0;
        ring_head              = 0;
        ring_held              = 0;
        next_rcv_seq           = '0;
        depth_setting          = DEPTH_RESET;
        lifespan_setting       = '0;
        error_count            = 0;
        cycle_count            = 0;
        rsp_hold_cycles        = 0;
        sender_burst           = 1'b0;
        rsp_burst              = 1'b0;
        sim_now                = '0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_field_extremes();
        test_depth_limits();
        test_lifespan_expiry();
        test_random_settings();
        test_output_stall();

        wait_results_done();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("keep_last_queue_with_lifespan_tb: clean");
        else
            $display("keep_last_queue_with_lifespan_tb: errors");
        $finish;
    end

endmodule
